### rtl/core/dotq_pkg.sv
// Package for the deadline ordered task queue: field widths, command and
// status codes, and the item and entry types. No dependencies.
`timescale 1ns / 1ps
package dotq_pkg;
	localparam int ID_W   = 8;
	localparam int TIME_W = 32;

	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_REMOVE  = 2'd2;
	localparam logic [1:0] CMD_DEQUEUE = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ID_W-1:0]   task_id;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] elapsed;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] out_task_id;
		logic [1:0]      status;
		logic            last;
	} rsp_t;

	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [ID_W-1:0]   id;
	} entry_t;
endpackage

### rtl/core/dotq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dotq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/deadline_ordered_task_queue.sv
// Top level of the deadline ordered task queue: command sequencer around one
// entry RAM. Depends on dotq_pkg and dotq_ram.
`timescale 1ns / 1ps
// The queue keeps up to MAX_TASKS tasks in deadline order in a circular buffer
// held in one RAM. A command is taken when start is high and busy is low; its
// results appear with rsp_valid, one at a time, and cannot be held off. The RAM
// walk moves one entry per cycle: dequeue reads the head entry, insert walks
// from the tail past the entries with later deadlines, tick visits every entry,
// and remove scans to the match and then shifts the entries ahead of it.
// There is no clearing pass after reset.
module deadline_ordered_task_queue #(
	parameter int MAX_TASKS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dotq_pkg::req_t req,
	output logic          rsp_valid,
	output dotq_pkg::rsp_t rsp
);
	import dotq_pkg::*;

	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int EW = TIME_W + ID_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INS    = 3'd1;
	localparam logic [2:0] S_PUT    = 3'd2;
	localparam logic [2:0] S_TICK   = 3'd3;
	localparam logic [2:0] S_TEND   = 3'd4;
	localparam logic [2:0] S_RSCAN  = 3'd5;
	localparam logic [2:0] S_RSHIFT = 3'd6;
	localparam logic [2:0] S_DEQ    = 3'd7;

	logic [2:0]        st_q, st_d;
	logic [AW-1:0]     head_q, head_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     idx_q, idx_d;
	logic [CW-1:0]     w1_q, w1_d;
	logic [ID_W-1:0]   id_q, id_d;
	logic [TIME_W-1:0] tm_q, tm_d;
	logic [ID_W-1:0]   pend_q, pend_d;
	logic              pendv_q, pendv_d;
	logic              ov_q, ov_d;
	rsp_t              rsp_q, rsp_d;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	entry_t            wdata, rdata;
	logic [EW-1:0]     rdata_raw;

	// Maps a logical queue position to its RAM address.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
		logic [CW:0] s;
		s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, l};
		if (s >= (CW + 1)'(MAX_TASKS)) begin
			s = s - (CW + 1)'(MAX_TASKS);
		end
		return s[AW-1:0];
	endfunction

	dotq_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rdata = entry_t'(rdata_raw);

	always_comb begin
		st_d    = st_q;
		head_d  = head_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		w1_d    = w1_q;
		id_d    = id_q;
		tm_d    = tm_q;
		pend_d  = pend_q;
		pendv_d = pendv_q;
		ov_d    = 1'b0;
		rsp_d   = rsp_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = rdata;
		raddr   = '0;
		case (st_q)
			S_IDLE: begin
				if (start) begin
					id_d = req.task_id;
					tm_d = (req.cmd == CMD_TICK) ? req.elapsed : req.deadline;
					case (req.cmd)
						CMD_INSERT: begin
							if (cnt_q == CW'(MAX_TASKS)) begin
								ov_d  = 1'b1;
								rsp_d = '{out_task_id: '0, status: ST_FULL, last: 1'b1};
							end else if (req.task_id == '0) begin
								ov_d  = 1'b1;
								rsp_d = '{out_task_id: '0, status: ST_NONE, last: 1'b1};
							end else if (cnt_q == '0) begin
								idx_d = '0;
								st_d  = S_PUT;
							end else begin
								raddr = phys(head_q, cnt_q - 1'b1);
								idx_d = cnt_q - 1'b1;
								st_d  = S_INS;
							end
						end
						CMD_TICK: begin
							if (cnt_q == '0) begin
								ov_d  = 1'b1;
								rsp_d = '{out_task_id: '0, status: ST_NONE, last: 1'b1};
							end else begin
								raddr   = phys(head_q, cnt_q - 1'b1);
								idx_d   = cnt_q - 1'b1;
								w1_d    = cnt_q;
								pendv_d = 1'b0;
								st_d    = S_TICK;
							end
						end
						CMD_REMOVE: begin
							if (cnt_q == '0 || req.task_id == '0) begin
								ov_d  = 1'b1;
								rsp_d = '{out_task_id: '0, status: ST_NONE, last: 1'b1};
							end else begin
								raddr = head_q;
								idx_d = '0;
								st_d  = S_RSCAN;
							end
						end
						default: begin
							if (cnt_q == '0) begin
								ov_d  = 1'b1;
								rsp_d = '{out_task_id: '0, status: ST_NONE, last: 1'b1};
							end else begin
								raddr = head_q;
								st_d  = S_DEQ;
							end
						end
					endcase
				end
			end
			S_INS: begin
				we    = 1'b1;
				waddr = phys(head_q, idx_q + 1'b1);
				if (rdata.deadline > tm_q) begin
					wdata = rdata;
					if (idx_q == '0) begin
						st_d = S_PUT;
					end else begin
						raddr = phys(head_q, idx_q - 1'b1);
						idx_d = idx_q - 1'b1;
					end
				end else begin
					wdata = '{deadline: tm_q, id: id_q};
					cnt_d = cnt_q + 1'b1;
					ov_d  = 1'b1;
					rsp_d = '{out_task_id: '0, status: ST_OK, last: 1'b1};
					st_d  = S_IDLE;
				end
			end
			S_PUT: begin
				we    = 1'b1;
				waddr = phys(head_q, idx_q);
				wdata = '{deadline: tm_q, id: id_q};
				cnt_d = cnt_q + 1'b1;
				ov_d  = 1'b1;
				rsp_d = '{out_task_id: '0, status: ST_OK, last: 1'b1};
				st_d  = S_IDLE;
			end
			S_TICK: begin
				// Survivors are packed toward the tail; the expired id is held
				// back one step so that the final one can carry last.
				if (rdata.deadline <= tm_q) begin
					if (pendv_q) begin
						ov_d  = 1'b1;
						rsp_d = '{out_task_id: pend_q, status: ST_OK, last: 1'b0};
					end
					pend_d  = rdata.id;
					pendv_d = 1'b1;
				end else begin
					we    = 1'b1;
					waddr = phys(head_q, w1_q - 1'b1);
					wdata = '{deadline: rdata.deadline - tm_q, id: rdata.id};
					w1_d  = w1_q - 1'b1;
				end
				if (idx_q == '0) begin
					head_d = phys(head_q, w1_d);
					cnt_d  = cnt_q - w1_d;
					st_d   = S_TEND;
				end else begin
					raddr = phys(head_q, idx_q - 1'b1);
					idx_d = idx_q - 1'b1;
				end
			end
			S_TEND: begin
				ov_d = 1'b1;
				if (pendv_q) begin
					rsp_d = '{out_task_id: pend_q, status: ST_OK, last: 1'b1};
				end else begin
					rsp_d = '{out_task_id: '0, status: ST_NONE, last: 1'b1};
				end
				st_d = S_IDLE;
			end
			S_RSCAN: begin
				if (rdata.id == id_q) begin
					if (idx_q == '0) begin
						head_d = phys(head_q, CW'(1));
						cnt_d  = cnt_q - 1'b1;
						ov_d   = 1'b1;
						rsp_d  = '{out_task_id: id_q, status: ST_OK, last: 1'b1};
						st_d   = S_IDLE;
					end else begin
						raddr = phys(head_q, idx_q - 1'b1);
						idx_d = idx_q - 1'b1;
						st_d  = S_RSHIFT;
					end
				end else if (idx_q == cnt_q - 1'b1) begin
					ov_d  = 1'b1;
					rsp_d = '{out_task_id: '0, status: ST_NONE, last: 1'b1};
					st_d  = S_IDLE;
				end else begin
					raddr = phys(head_q, idx_q + 1'b1);
					idx_d = idx_q + 1'b1;
				end
			end
			S_RSHIFT: begin
				// Entries ahead of the match move one place toward the tail.
				we    = 1'b1;
				waddr = phys(head_q, idx_q + 1'b1);
				wdata = rdata;
				if (idx_q == '0) begin
					head_d = phys(head_q, CW'(1));
					cnt_d  = cnt_q - 1'b1;
					ov_d   = 1'b1;
					rsp_d  = '{out_task_id: id_q, status: ST_OK, last: 1'b1};
					st_d   = S_IDLE;
				end else begin
					raddr = phys(head_q, idx_q - 1'b1);
					idx_d = idx_q - 1'b1;
				end
			end
			S_DEQ: begin
				head_d = phys(head_q, CW'(1));
				cnt_d  = cnt_q - 1'b1;
				ov_d   = 1'b1;
				rsp_d  = '{out_task_id: rdata.id, status: ST_OK, last: 1'b1};
				st_d   = S_IDLE;
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			pendv_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			st_q    <= st_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			pendv_q <= pendv_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		w1_q   <= w1_d;
		id_q   <= id_d;
		tm_q   <= tm_d;
		pend_q <= pend_d;
		rsp_q  <= rsp_d;
	end

	assign busy      = (st_q != S_IDLE);
	assign rsp_valid = ov_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_TASKS))
		else $error("entry count above capacity");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < AW'(MAX_TASKS) || AW'(MAX_TASKS) == '0)
		else $error("head pointer out of range");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !we)
		else $error("RAM write while idle");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_FULL) |-> cnt_q == CW'(MAX_TASKS))
		else $error("full status with free entries");
`endif
endmodule
